// ===== rtl/otpwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package otpwm_pkg;

    localparam int AXES   = 3;
    localparam int WHEELS = 4;

    // Limits, Q.8
    localparam logic signed [23:0] LIM_INT_XY  = 24'sd76800;
    localparam logic signed [23:0] LIM_INT_YAW = 24'sd2560;
    localparam logic [47:0]        LIM_D       = 48'd38400;
    localparam logic signed [31:0] LIM_SUM     = 32'sd307200;

    // Mixing and scaling constants
    localparam logic [23:0] MIX_C    = 24'd46341;
    localparam logic [23:0] YAW_MIX  = 24'd6553600;
    localparam logic [23:0] USEC     = 24'd1000000;
    localparam logic signed [57:0] WHEEL_OFFS = 58'sd838860800;

    typedef enum logic [1:0] {
        REG_GAIN_P      = 2'd0,
        REG_GAIN_I      = 2'd1,
        REG_GAIN_D      = 2'd2,
        REG_DRIVE_SCALE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               cmd;
        logic signed [19:0] target_x;
        logic signed [19:0] target_y;
        logic signed [19:0] target_yaw;
        logic signed [19:0] meas_x;
        logic signed [19:0] meas_y;
        logic signed [19:0] meas_yaw;
        logic [17:0]        tick_us;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [15:0] drive_0;
        logic signed [15:0] drive_1;
        logic signed [15:0] drive_2;
        logic signed [15:0] drive_3;
        logic               overrun_fault;
        logic [3:0]         cut_mask;
    } drv_beat_t;

endpackage

`default_nettype wire

// ===== rtl/omni_three_axis_pid_wheel_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                        | Dir | Payload
// cmd      | cmd_valid, cmd_ready, cmd_data | in  | cmd_beat_t
// drv      | drv_valid, drv_ready, drv_data | out | drv_beat_t
// cfg      | cfg_we, cfg_index, cfg_data    | in  | 24-bit register write
//
// A target beat (cmd 0) only loads the targets and leaves the sequencer idle. In a tick beat
// each product runs through a shift-add multiplier, one multiplier bit a cycle, and each
// quotient through a restoring divider (one microsecond divide per axis, one dt divide per
// axis unless the D product saturates, one more per uncut wheel for the scale). An overrun
// at any axis ends the tick. An idle tick with all targets zero goes straight to the
// output. rst_n clears the sequencer, targets, integrators and last errors at once.
// cmd_ready is high only between ticks; a result holds on drv_data until drv_ready
// takes it.

module omni_three_axis_pid_wheel_mixer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [23:0]           cfg_data,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire otpwm_pkg::cmd_beat_t  cmd_data,
    output logic                       drv_valid,
    input  wire logic                  drv_ready,
    output otpwm_pkg::drv_beat_t       drv_data
);

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_ERR  = 17'h00002,
        S_P    = 17'h00004,
        S_EI   = 17'h00008,
        S_DI   = 17'h00010,
        S_I    = 17'h00020,
        S_DM   = 17'h00040,
        S_DN   = 17'h00080,
        S_DD   = 17'h00100,
        S_SUM  = 17'h00200,
        S_M0   = 17'h00400,
        S_M1   = 17'h00800,
        S_M2   = 17'h01000,
        S_M3   = 17'h02000,
        S_W    = 17'h04000,
        S_WD   = 17'h08000,
        S_OUT  = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg, scale_reg;
    logic [23:0] scale_eff;

    logic signed [19:0] tgt_reg   [otpwm_pkg::AXES];
    logic signed [19:0] tgt_next  [otpwm_pkg::AXES];
    logic signed [19:0] meas_reg  [otpwm_pkg::AXES];
    logic signed [19:0] meas_next [otpwm_pkg::AXES];
    logic signed [17:0] integ_reg [otpwm_pkg::AXES];
    logic signed [17:0] integ_next[otpwm_pkg::AXES];
    logic signed [20:0] lerr_reg  [otpwm_pkg::AXES];
    logic signed [20:0] lerr_next [otpwm_pkg::AXES];
    logic signed [31:0] sums_reg  [otpwm_pkg::AXES];
    logic signed [31:0] sums_next [otpwm_pkg::AXES];
    logic [15:0]        drive_reg [otpwm_pkg::WHEELS];
    logic [15:0]        drive_next[otpwm_pkg::WHEELS];

    logic [17:0]        tick_reg, tick_next;
    logic signed [20:0] err_reg, err_next;
    logic               diff_neg_reg, diff_neg_next;
    logic signed [31:0] sum_reg, sum_next;
    logic [15:0]        dmag_reg, dmag_next;
    logic signed [57:0] wz_reg, wz_next, cx_reg, cx_next, cy_reg, cy_next;
    logic               w_pos_reg, w_pos_next;
    logic [1:0]         ax_reg, ax_next, wh_reg, wh_next;
    logic [3:0]         mask_reg, mask_next;
    logic               fault_reg, fault_next;

    // Shift-add multiplier, one multiplier bit per cycle
    logic [71:0] mul_a_reg, mul_acc_reg;
    logic [23:0] mul_b_reg;
    logic        mul_busy_reg, mul_neg_reg;
    logic        mul_start, mul_neg_in;
    logic [47:0] mul_a_in;
    logic [23:0] mul_b_in;

    // Restoring divider, one quotient bit per cycle
    logic [63:0] div_q_reg;
    logic [23:0] div_rem_reg, div_d_reg;
    logic [6:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic        div_start;
    logic [63:0] div_n_in;
    logic [23:0] div_d_in;
    logic [24:0] div_trial;
    logic        div_ge;

    // Datapath helpers
    logic signed [20:0] err_full;
    logic [20:0]        err_full_abs;
    logic signed [72:0] prod_s;
    logic signed [72:0] prod_q16;
    logic [20:0]        step_mag;
    logic signed [23:0] step_s, u_raw, u_lim;
    logic signed [17:0] u_cl;
    logic [17:0]        u_abs;
    logic signed [21:0] diff;
    logic [21:0]        diff_abs;
    logic signed [31:0] s_new;
    logic [31:0]        s_abs;
    logic signed [31:0] s_sel;
    logic signed [57:0] w_raw, w_off;
    logic [57:0]        w_mag;
    logic [66:0]        cut_lhs, cut_rhs;
    logic               cut;
    logic [47:0]        num;
    logic [47:0]        dq;
    logic               targets_zero;

    function automatic logic [20:0] err_abs_of(input logic signed [20:0] e);
        err_abs_of = e[20] ? 21'(-e) : 21'(e);
    endfunction

    assign scale_eff = (scale_reg == 24'd0) ? 24'd1 : scale_reg;
    assign targets_zero = (tgt_reg[0] == 20'sd0) && (tgt_reg[1] == 20'sd0)
                       && (tgt_reg[2] == 20'sd0);

    // Error and magnitude for the current axis
    assign err_full = 21'({tgt_reg[ax_reg][19], tgt_reg[ax_reg]})
                    - 21'({meas_reg[ax_reg][19], meas_reg[ax_reg]});
    assign err_full_abs = err_full[20] ? 21'(-err_full) : 21'(err_full);

    // Signed product from magnitude and the sign latched at start
    assign prod_s   = mul_neg_reg ? -$signed({1'b0, mul_acc_reg}) : $signed({1'b0, mul_acc_reg});
    assign prod_q16 = prod_s >>> 16;

    // Integrator update with floor of err*dt/1e6
    assign step_mag = div_q_reg[20:0] + 21'((err_reg[20] && div_rem_reg != 24'd0) ? 1 : 0);
    assign step_s   = err_reg[20] ? -$signed({3'b0, step_mag}) : $signed({3'b0, step_mag});
    assign u_raw    = 24'({{6{integ_reg[ax_reg][17]}}, integ_reg[ax_reg]}) + step_s;
    always_comb
    begin
        u_lim = (ax_reg == 2'd2) ? otpwm_pkg::LIM_INT_YAW : otpwm_pkg::LIM_INT_XY;
        if (u_raw > u_lim)
            u_cl = u_lim[17:0];
        else if (u_raw < -u_lim)
            u_cl = 18'(-u_lim);
        else
            u_cl = u_raw[17:0];
    end
    assign u_abs = u_cl[17] ? 18'(-u_cl) : 18'(u_cl);

    // Error change for the D term
    assign diff     = 22'({err_reg[20], err_reg}) - 22'({lerr_reg[ax_reg][20], lerr_reg[ax_reg]});
    assign diff_abs = diff[21] ? 22'(-diff) : 22'(diff);
    assign num      = mul_acc_reg[47:0];
    assign dq       = div_q_reg[63:16];
    assign s_new    = sum_reg + (diff_neg_reg ? -$signed({16'b0, dmag_reg})
                                              : $signed({16'b0, dmag_reg}));

    // Magnitude of an axis sum for mixing
    always_comb
    begin
        case (state_reg)
            S_M0:    s_sel = sums_reg[2];
            S_M1:    s_sel = sums_reg[0];
            default: s_sel = sums_reg[1];
        endcase
    end
    assign s_abs = s_sel[31] ? 32'(-s_sel) : 32'(s_sel);

    // Wheel mix: x sign is + on wheels 2 and 3, y sign is + on wheels 0 and 3
    assign w_raw = wz_reg + (wh_reg[1] ? cx_reg : -cx_reg)
                 + ((wh_reg[0] == wh_reg[1]) ? cy_reg : -cy_reg);
    always_comb
    begin
        if (w_raw > 58'sd0)
            w_off = w_raw + otpwm_pkg::WHEEL_OFFS;
        else if (w_raw < 58'sd0)
            w_off = w_raw - otpwm_pkg::WHEEL_OFFS;
        else
            w_off = 58'sd0;
    end
    assign w_mag   = w_off[57] ? 58'(-w_off) : 58'(w_off);
    assign cut_lhs = ({9'b0, w_mag} << 9) + ({9'b0, w_mag} << 7);
    assign cut_rhs = ({43'b0, scale_eff} << 16) + ({43'b0, scale_eff} << 15);
    assign cut     = cut_lhs > cut_rhs;

    // Divider step
    assign div_trial = {div_rem_reg, div_q_reg[63]};
    assign div_ge    = div_trial >= {1'b0, div_d_reg};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        tgt_next      = tgt_reg;
        meas_next     = meas_reg;
        integ_next    = integ_reg;
        lerr_next     = lerr_reg;
        sums_next     = sums_reg;
        drive_next    = drive_reg;
        tick_next     = tick_reg;
        err_next      = err_reg;
        diff_neg_next = diff_neg_reg;
        sum_next      = sum_reg;
        dmag_next     = dmag_reg;
        wz_next       = wz_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        w_pos_next    = w_pos_reg;
        ax_next       = ax_reg;
        wh_next       = wh_reg;
        mask_next     = mask_reg;
        fault_next    = fault_reg;
        mul_start     = 1'b0;
        mul_neg_in    = 1'b0;
        mul_a_in      = 48'd0;
        mul_b_in      = 24'd0;
        div_start     = 1'b0;
        div_n_in      = 64'd0;
        div_d_in      = 24'd1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd_data.cmd)
                    begin
                        tgt_next[0] = cmd_data.target_x;
                        tgt_next[1] = cmd_data.target_y;
                        tgt_next[2] = cmd_data.target_yaw;
                    end
                    else
                    begin
                        meas_next[0] = cmd_data.meas_x;
                        meas_next[1] = cmd_data.meas_y;
                        meas_next[2] = cmd_data.meas_yaw;
                        tick_next = (cmd_data.tick_us == 18'd0) ? 18'd1 : cmd_data.tick_us;
                        for (int k = 0; k < otpwm_pkg::WHEELS; k++)
                            drive_next[k] = 16'd0;
                        mask_next  = 4'd0;
                        fault_next = 1'b0;
                        ax_next    = 2'd0;
                        if (targets_zero)
                        begin
                            for (int a = 0; a < otpwm_pkg::AXES; a++)
                            begin
                                integ_next[a] = 18'sd0;
                                lerr_next[a]  = 21'sd0;
                            end
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_ERR;
                    end
                end
            end

            // P = floor(gain_p * err / 2^16)
            S_ERR:
            begin
                err_next   = err_full;
                mul_start  = 1'b1;
                mul_neg_in = err_full[20];
                mul_a_in   = 48'(gain_p_reg);
                mul_b_in   = 24'(err_full_abs);
                state_next = S_P;
            end

            S_P:
            begin
                if (!mul_busy_reg)
                begin
                    sum_next   = prod_q16[31:0];
                    mul_start  = 1'b1;
                    mul_a_in   = 48'(err_abs_of(err_reg));
                    mul_b_in   = 24'(tick_reg);
                    state_next = S_EI;
                end
            end

            S_EI:
            begin
                if (!mul_busy_reg)
                begin
                    div_start  = 1'b1;
                    div_n_in   = mul_acc_reg[63:0];
                    div_d_in   = otpwm_pkg::USEC;
                    state_next = S_DI;
                end
            end

            // Integrate, clamp, then I = floor(gain_i * u / 2^16)
            S_DI:
            begin
                if (!div_busy_reg)
                begin
                    integ_next[ax_reg] = u_cl;
                    mul_start  = 1'b1;
                    mul_neg_in = u_cl[17];
                    mul_a_in   = 48'(gain_i_reg);
                    mul_b_in   = 24'(u_abs);
                    state_next = S_I;
                end
            end

            S_I:
            begin
                if (!mul_busy_reg)
                begin
                    sum_next      = sum_reg + prod_q16[31:0];
                    diff_neg_next = diff[21];
                    mul_start     = 1'b1;
                    mul_a_in      = 48'(gain_d_reg);
                    mul_b_in      = 24'(diff_abs);
                    state_next    = S_DM;
                end
            end

            S_DM:
            begin
                if (!mul_busy_reg)
                begin
                    if (num[47:44] != 4'd0)
                    begin
                        dmag_next  = otpwm_pkg::LIM_D[15:0];
                        state_next = S_SUM;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a_in   = num;
                        mul_b_in   = otpwm_pkg::USEC;
                        state_next = S_DN;
                    end
                end
            end

            S_DN:
            begin
                if (!mul_busy_reg)
                begin
                    div_start  = 1'b1;
                    div_n_in   = mul_acc_reg[63:0];
                    div_d_in   = 24'(tick_reg);
                    state_next = S_DD;
                end
            end

            S_DD:
            begin
                if (!div_busy_reg)
                begin
                    dmag_next  = (dq > otpwm_pkg::LIM_D) ? otpwm_pkg::LIM_D[15:0] : dq[15:0];
                    state_next = S_SUM;
                end
            end

            // Overrun check, then next axis or mixing
            S_SUM:
            begin
                if (s_new > otpwm_pkg::LIM_SUM)
                begin
                    for (int a = 0; a < otpwm_pkg::AXES; a++)
                    begin
                        integ_next[a] = 18'sd0;
                        lerr_next[a]  = 21'sd0;
                        tgt_next[a]   = 20'sd0;
                    end
                    fault_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    lerr_next[ax_reg] = err_reg;
                    sums_next[ax_reg] = s_new;
                    if (ax_reg == 2'd2)
                        state_next = S_M0;
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_ERR;
                    end
                end
            end

            S_M0:
            begin
                mul_start  = 1'b1;
                mul_neg_in = s_sel[31];
                mul_a_in   = 48'(s_abs);
                mul_b_in   = otpwm_pkg::YAW_MIX;
                state_next = S_M1;
            end

            S_M1:
            begin
                if (!mul_busy_reg)
                begin
                    wz_next    = prod_s[57:0];
                    mul_start  = 1'b1;
                    mul_neg_in = s_sel[31];
                    mul_a_in   = 48'(s_abs);
                    mul_b_in   = otpwm_pkg::MIX_C;
                    state_next = S_M2;
                end
            end

            S_M2:
            begin
                if (!mul_busy_reg)
                begin
                    cx_next    = prod_s[57:0];
                    mul_start  = 1'b1;
                    mul_neg_in = s_sel[31];
                    mul_a_in   = 48'(s_abs);
                    mul_b_in   = otpwm_pkg::MIX_C;
                    state_next = S_M3;
                end
            end

            S_M3:
            begin
                if (!mul_busy_reg)
                begin
                    cy_next    = prod_s[57:0];
                    wh_next    = 2'd0;
                    state_next = S_W;
                end
            end

            // Per wheel: cut check, else divide by the scale
            S_W:
            begin
                w_pos_next = w_off > 58'sd0;
                if (cut)
                begin
                    mask_next[wh_reg] = 1'b1;
                    if (wh_reg == 2'd3)
                        state_next = S_OUT;
                    else
                        wh_next = wh_reg + 2'd1;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n_in   = {w_mag[56:0], 7'b0};
                    div_d_in   = scale_eff;
                    state_next = S_WD;
                end
            end

            S_WD:
            begin
                if (!div_busy_reg)
                begin
                    drive_next[wh_reg] = w_pos_reg ? 16'(-div_q_reg[15:0]) : div_q_reg[15:0];
                    if (wh_reg == 2'd3)
                        state_next = S_OUT;
                    else
                    begin
                        wh_next    = wh_reg + 2'd1;
                        state_next = S_W;
                    end
                end
            end

            S_OUT:
            begin
                if (drv_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            gain_p_reg   <= 24'd0;
            gain_i_reg   <= 24'd0;
            gain_d_reg   <= 24'd0;
            scale_reg    <= 24'd65536;
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            for (int a = 0; a < otpwm_pkg::AXES; a++)
            begin
                tgt_reg[a]   <= 20'sd0;
                integ_reg[a] <= 18'sd0;
                lerr_reg[a]  <= 21'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            integ_reg <= integ_next;
            lerr_reg  <= lerr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    otpwm_pkg::REG_GAIN_P:      gain_p_reg <= cfg_data;
                    otpwm_pkg::REG_GAIN_I:      gain_i_reg <= cfg_data;
                    otpwm_pkg::REG_GAIN_D:      gain_d_reg <= cfg_data;
                    otpwm_pkg::REG_DRIVE_SCALE: scale_reg  <= cfg_data;
                    default:                    scale_reg  <= scale_reg;
                endcase
            end
            if (mul_start)
                mul_busy_reg <= 1'b1;
            else if (mul_b_reg == 24'd0)
                mul_busy_reg <= 1'b0;
            if (div_start)
                div_busy_reg <= 1'b1;
            else if (div_cnt_reg == 7'd1)
                div_busy_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        sums_reg     <= sums_next;
        drive_reg    <= drive_next;
        tick_reg     <= tick_next;
        err_reg      <= err_next;
        diff_neg_reg <= diff_neg_next;
        sum_reg      <= sum_next;
        dmag_reg     <= dmag_next;
        wz_reg       <= wz_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        w_pos_reg    <= w_pos_next;
        ax_reg       <= ax_next;
        wh_reg       <= wh_next;
        mask_reg     <= mask_next;
        fault_reg    <= fault_next;

        // Multiplier: add shifted multiplicand for each set multiplier bit
        if (mul_start)
        begin
            mul_a_reg   <= {24'd0, mul_a_in};
            mul_b_reg   <= mul_b_in;
            mul_acc_reg <= 72'd0;
            mul_neg_reg <= mul_neg_in;
        end
        else if (mul_busy_reg && mul_b_reg != 24'd0)
        begin
            if (mul_b_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end

        // Divider: shift in one dividend bit, subtract when it fits
        if (div_start)
        begin
            div_q_reg   <= div_n_in;
            div_rem_reg <= 24'd0;
            div_d_reg   <= div_d_in;
            div_cnt_reg <= 7'd64;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? 24'(div_trial - {1'b0, div_d_reg}) : div_trial[23:0];
            div_q_reg   <= {div_q_reg[62:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 7'd1;
        end
    end

    // Ports
    assign cmd_ready = (state_reg == S_IDLE);
    assign drv_valid = (state_reg == S_OUT);
    assign drv_data.drive_0       = drive_reg[0];
    assign drv_data.drive_1       = drive_reg[1];
    assign drv_data.drive_2       = drive_reg[2];
    assign drv_data.drive_3       = drive_reg[3];
    assign drv_data.overrun_fault = fault_reg;
    assign drv_data.cut_mask      = mask_reg;

endmodule

`default_nettype wire
